// ===== rtl/core/lstk_pkg.sv =====
package lstk_pkg;

  // request codes carried on action_i
  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;

  // control of the stack memory port
  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

endpackage

// ===== rtl/core/lifo_stack_with_search.sv =====
// LIFO stack of signed 32-bit words with push, pop, peek and key search.
// Requests: drive action_i and value_i with start_i high; the request is
// taken at a rising edge where start_i is high and busy_o is low.
// Results: done_o is high for exactly one cycle with data_out_o, found_o,
// entry_count_o, is_empty_o and status_o valid in that cycle. The receiver
// cannot stall; results are not held.
// Handling of a request from the request edge to the done_o cycle:
//   push, refused push, pop/peek on empty, search on empty: done_o in the
//   next cycle. pop and peek: one read of the stack memory, then done_o.
//   search: the key is compared against one stored entry per cycle
//   through the single memory read port, up to DEPTH entries.
// busy_o is low again in the done_o cycle, so a new request can be taken at
// the edge that ends it. One request is handled at a time.
// Reset: the entry count clears to zero at once; the memory itself is not
// cleared since only entries below the count are ever read.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         action_i,
  input  logic signed [lstk_pkg::WordW-1:0]  value_i,
  output logic                               done_o,
  output logic signed [lstk_pkg::WordW-1:0]  data_out_o,
  output logic                               found_o,
  output logic [lstk_pkg::CountW-1:0]        entry_count_o,
  output logic                               is_empty_o,
  output logic [1:0]                         status_o
);
  import lstk_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         count_q;
  logic [CntW-1:0]         scan_idx_q;
  logic                    pop_q;
  logic                    hit_q;
  logic signed [WordW-1:0] key_q;
  logic                    done_q;
  logic signed [WordW-1:0] data_q;
  logic                    found_q;
  status_e                 status_q;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [CntW-1:0]         cnt_m1;
  logic                    match;
  logic                    scan_last;
  mem_req_t                mem_req;
  logic [AddrW-1:0]        mem_addr;
  logic signed [WordW-1:0] rdata;
  logic [CntW+CountW-1:0]  count_ext;

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i & ~busy_o;
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q - 1'b1;
  assign match     = (rdata == key_q);
  assign scan_last = (scan_idx_q == count_q);

  // memory port control: push writes, pop/peek and search read
  always_comb begin
    mem_req  = '0;
    mem_addr = '0;
    if (accept) begin
      unique case (action_i)
        ACT_PUSH: begin
          mem_req.we = ~full;
          mem_addr   = count_q[AddrW-1:0];
        end
        ACT_POP, ACT_PEEK: begin
          mem_req.re = ~empty;
          mem_addr   = cnt_m1[AddrW-1:0];
        end
        ACT_SEARCH: begin
          mem_req.re = ~empty;
          mem_addr   = '0;
        end
        default: begin
          mem_req = '0;
        end
      endcase
    end else if (state_q == S_SCAN && !scan_last) begin
      mem_req.re = 1'b1;
      mem_addr   = scan_idx_q[AddrW-1:0];
    end
  end

  lstk_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .wdata_i (value_i),
    .rdata_o (rdata)
  );

  // request sequencer with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      scan_idx_q <= '0;
      pop_q      <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      status_q   <= ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q   <= value_i;
            pop_q   <= (action_i == ACT_POP);
            data_q  <= '0;
            found_q <= 1'b0;
            unique case (action_i)
              ACT_PUSH: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_OVER;
                end else begin
                  status_q <= ST_OK;
                  count_q  <= count_q + 1'b1;
                end
              end
              ACT_POP, ACT_PEEK: begin
                if (empty) begin
                  done_q   <= 1'b1;
                  status_q <= ST_UNDER;
                end else begin
                  state_q <= S_READ;
                end
              end
              ACT_SEARCH: begin
                if (empty) begin
                  done_q   <= 1'b1;
                  status_q <= ST_OK;
                end else begin
                  state_q    <= S_SCAN;
                  scan_idx_q <= CntW'(1);
                  hit_q      <= 1'b0;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          done_q   <= 1'b1;
          data_q   <= rdata;
          status_q <= ST_OK;
          if (pop_q) begin
            count_q <= cnt_m1;
          end
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          // compare the entry read last cycle, stop after the top entry
          if (scan_last) begin
            done_q   <= 1'b1;
            found_q  <= hit_q | match;
            status_q <= ST_OK;
            state_q  <= S_IDLE;
          end else begin
            hit_q      <= hit_q | match;
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign count_ext     = {{CountW{1'b0}}, count_q};
  assign done_o        = done_q;
  assign data_out_o    = data_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[CountW-1:0];
  assign is_empty_o    = empty;

  // count never exceeds the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  // an accepted push on a non-full stack grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_PUSH && !full) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the count");

  // underflow only reported on an empty stack with zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_UNDER) |-> (empty && data_q == '0))
    else $error("bad underflow result");

  // the scan pointer stays within the held entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_idx_q != '0 && scan_idx_q <= count_q))
    else $error("scan pointer out of range");

endmodule

// ===== rtl/core/lstk_mem.sv =====
module lstk_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  lstk_pkg::mem_req_t                 req_i,
  input  logic [$clog2(DEPTH)-1:0]           addr_i,
  input  logic signed [lstk_pkg::WordW-1:0]  wdata_i,
  output logic signed [lstk_pkg::WordW-1:0]  rdata_o
);
  import lstk_pkg::*;

  logic signed [WordW-1:0] mem_q [DEPTH];
  logic signed [WordW-1:0] rdata_q;

  // single port storage, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
